@@ hdl/tmwf_pkg.sv @@
// tmwf_pkg: shared types and constants of the trimmed mean window filter
// no dependencies; imported by every module of the block
`default_nettype none

package tmwf_pkg;

    // width of one sample and of one result
    localparam int SAMPLE_W = 32;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TRIM,
        ST_START,
        ST_DIV
    } state_t;

    // accumulator control from the sequencer
    typedef struct packed {
        logic en;
        logic first;
    } acc_ctrl_t;

    // divider control and status
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
    } div_stat_t;

endpackage

`default_nettype wire

@@ hdl/tmwf_cell.sv @@
// tmwf_cell: one window cell, a sample register that loads from its neighbor
// depends on tmwf_pkg
`default_nettype none

module tmwf_cell
(
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [tmwf_pkg::SAMPLE_W-1:0] d,
    output logic signed [tmwf_pkg::SAMPLE_W-1:0]      q
);
    import tmwf_pkg::*;

    logic signed [SAMPLE_W-1:0] q_reg;
    logic signed [SAMPLE_W-1:0] q_next;

    // hold unless the chain moves
    always_comb
    begin
        q_next = en ? d : q_reg;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ hdl/tmwf_accum.sv @@
// tmwf_accum: running sum, minimum and maximum over samples leaving the chain
// depends on tmwf_pkg
`default_nettype none

module tmwf_accum
#(
    parameter int SUM_W = 35
)
(
    input  wire logic                                clk,
    input  wire tmwf_pkg::acc_ctrl_t                 ctrl,
    input  wire logic signed [tmwf_pkg::SAMPLE_W-1:0] value,
    output logic signed [SUM_W-1:0]                  sum,
    output logic signed [tmwf_pkg::SAMPLE_W-1:0]      min_val,
    output logic signed [tmwf_pkg::SAMPLE_W-1:0]      max_val
);
    import tmwf_pkg::*;

    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic signed [SUM_W-1:0]    value_ext;

    assign value_ext = SUM_W'(value);

    always_comb
    begin
        sum_next = sum_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.en)
        begin
            if (ctrl.first)
            begin
                sum_next = value_ext;
                min_next = value;
                max_next = value;
            end
            else
            begin
                sum_next = sum_reg + value_ext;
                if (value < min_reg)
                begin
                    min_next = value;
                end
                if (value > max_reg)
                begin
                    max_next = value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        min_reg <= min_next;
        max_reg <= max_next;
    end

    assign sum     = sum_reg;
    assign min_val = min_reg;
    assign max_val = max_reg;

endmodule

`default_nettype wire

@@ hdl/tmwf_div.sv @@
// tmwf_div: division by the constant WINDOW-2 as a reciprocal multiply, one 16-bit digit a cycle
// depends on tmwf_pkg; truncates toward zero
`default_nettype none

module tmwf_div
#(
    parameter int WINDOW = 8,
    parameter int SUM_W  = 35
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tmwf_pkg::div_ctrl_t            ctrl,
    input  wire logic signed [SUM_W-1:0]        dividend,
    output tmwf_pkg::div_stat_t                 stat,
    output logic signed [tmwf_pkg::SAMPLE_W-1:0] quotient
);
    import tmwf_pkg::*;

    // magnitude of a trimmed sum always fits one bit below the sum width
    localparam int MAG_W   = SUM_W - 1;
    localparam int DIVISOR = WINDOW - 2;
    localparam int SHIFT   = MAG_W + $clog2(DIVISOR);
    localparam int RECIP_W = MAG_W + 2;
    localparam int DIGIT_W = 16;
    localparam int STEPS   = (MAG_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W   = STEPS * DIGIT_W;
    localparam int PROD_W  = PAD_W + RECIP_W;
    localparam int CNT_W   = $clog2(STEPS + 1);
    // floor(2^SHIFT / DIVISOR) + 1 gives the exact floor for any MAG_W-bit magnitude
    localparam logic [63:0] RECIP_VAL = ((64'd1 << SHIFT) / 64'(DIVISOR)) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_VAL[RECIP_W-1:0];

    logic [PAD_W-1:0]            mag_reg, mag_next;
    logic [PROD_W-1:0]           prod_reg, prod_next;
    logic                        neg_reg, neg_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic [MAG_W-1:0]            abs_dividend;
    logic [DIGIT_W-1:0]          digit;
    logic [RECIP_W+DIGIT_W-1:0]  partial;
    logic [SAMPLE_W-1:0]         mag;

    assign abs_dividend = MAG_W'(dividend[SUM_W-1] ? -dividend : dividend);

    // most significant digit first, one partial product a cycle
    assign digit   = mag_reg[PAD_W-1 -: DIGIT_W];
    assign partial = RECIP * digit;

    always_comb
    begin
        mag_next  = mag_reg;
        prod_next = prod_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctrl.start)
        begin
            neg_next  = dividend[SUM_W-1];
            mag_next  = PAD_W'(abs_dividend);
            prod_next = '0;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = (prod_reg << DIGIT_W) + PROD_W'(partial);
            mag_next  = mag_reg << DIGIT_W;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
    end

    // magnitude always fits in the sample width
    assign mag       = prod_reg[SHIFT +: SAMPLE_W];
    assign quotient  = neg_reg ? -mag : mag;
    assign stat.busy = busy_reg;

endmodule

`default_nettype wire

@@ hdl/trimmed_mean_window_filter.sv @@
// trimmed_mean_window_filter: moving mean over a window with one min and one max dropped
// depends on tmwf_pkg, tmwf_cell, tmwf_accum, tmwf_div
//
// usage
//   input channel sample_valid / sample_stall / sample carries one signed 32-bit
//   sample per transaction; output channel average_valid / average_stall / average
//   carries one signed 32-bit trimmed mean per transaction
//   the first WINDOW-1 samples after reset only fill the window and give no result;
//   from the WINDOW-th sample on every sample gives exactly one result
//   while filling, a new sample is taken every cycle; once full, the next sample is
//   taken only after the previous one has gone through one pass of the cell chain,
//   trim, divider start, the reciprocal multiply, output load and the return to
//   idle; the multiply works over DIV_STEPS = ceil((SUM_W - 1) / 16) digits of
//   16 bits, where SUM_W = 32 + clog2(WINDOW)
//   once the window is full, sample_stall is high from an input transaction until
//   its result is in the output register
//   a result waiting under average_stall holds the output register; the next
//   sample is still taken and worked on, and its result waits in the divider
//   reset clears the fill count, the sequencer and the output valid; the window
//   contents are only read once refilled
`default_nettype none

module trimmed_mean_window_filter
#(
    parameter int WINDOW = 8
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_valid,
    output logic                                     sample_stall,
    input  wire logic signed [tmwf_pkg::SAMPLE_W-1:0] sample,
    output logic                                     average_valid,
    input  wire logic                                average_stall,
    output logic signed [tmwf_pkg::SAMPLE_W-1:0]      average
);
    import tmwf_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;

    // sequencer
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic accept;
    logic full_now;
    logic chain_en;
    logic scanning;
    logic out_free;
    logic out_load;

    // cell chain
    logic signed [SAMPLE_W-1:0] cell_q [WINDOW];
    logic signed [SAMPLE_W-1:0] cell_d [WINDOW];

    // accumulator and divider
    acc_ctrl_t               acc_ctrl;
    div_ctrl_t               div_ctrl;
    div_stat_t               div_stat;
    logic signed [SUM_W-1:0] acc_sum;
    logic signed [SAMPLE_W-1:0] acc_min;
    logic signed [SAMPLE_W-1:0] acc_max;
    logic signed [SUM_W-1:0] trim_reg, trim_next;
    logic signed [SAMPLE_W-1:0] quotient;

    // output register
    logic                       avg_valid_reg, avg_valid_next;
    logic signed [SAMPLE_W-1:0] avg_reg, avg_next;

    assign accept   = sample_valid && !sample_stall;
    // this sample completes the window (or it was already full)
    assign full_now = (fill_reg >= FILL_W'(WINDOW - 1));
    assign scanning = (state_reg == ST_SCAN);
    // the chain shifts a new sample in, or rotates once around while scanning
    assign chain_en = accept || scanning;
    assign out_free = !avg_valid_reg || !average_stall;

    // new sample enters at cell 0; while scanning the last cell wraps to cell 0
    always_comb
    begin
        cell_d[0] = scanning ? cell_q[WINDOW-1] : sample;
        for (int i = 1; i < WINDOW; i++)
        begin
            cell_d[i] = cell_q[i-1];
        end
    end

    for (genvar g = 0; g < WINDOW; g++)
    begin : g_cell
        tmwf_cell u_cell
        (
            .clk (clk),
            .en  (chain_en),
            .d   (cell_d[g]),
            .q   (cell_q[g])
        );
    end

    // the value leaving the last cell feeds the accumulator each scan cycle
    assign acc_ctrl.en    = scanning;
    assign acc_ctrl.first = (scan_reg == '0);

    tmwf_accum #(.SUM_W(SUM_W)) u_accum
    (
        .clk     (clk),
        .ctrl    (acc_ctrl),
        .value   (cell_q[WINDOW-1]),
        .sum     (acc_sum),
        .min_val (acc_min),
        .max_val (acc_max)
    );

    assign div_ctrl.start = (state_reg == ST_START);

    tmwf_div #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (trim_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // next state and control
    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        fill_next    = fill_reg;
        trim_next    = trim_reg;
        out_load     = 1'b0;
        sample_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                // input is open here, so valid alone completes a transaction
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    if (fill_reg != FILL_W'(WINDOW))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (full_now)
                    begin
                        state_next = ST_SCAN;
                        scan_next  = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == CNT_W'(WINDOW - 1))
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                // drop one minimum and one maximum
                trim_next  = acc_sum - SUM_W'(acc_min) - SUM_W'(acc_max);
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_stat.busy && out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register, reloadable in the cycle its transaction completes
    always_comb
    begin
        avg_valid_next = avg_valid_reg;
        avg_next       = avg_reg;
        if (out_load)
        begin
            avg_valid_next = 1'b1;
            avg_next       = quotient;
        end
        else if (!average_stall)
        begin
            avg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            fill_reg      <= '0;
            avg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            fill_reg      <= fill_next;
            avg_valid_reg <= avg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trim_reg <= trim_next;
        avg_reg  <= avg_next;
    end

    assign average_valid = avg_valid_reg;
    assign average       = avg_reg;

endmodule

`default_nettype wire

@@ hdl/tmwf_checker.sv @@
// tmwf_checker: port-level assertions for trimmed_mean_window_filter, bound to it
// depends on tmwf_pkg and trimmed_mean_window_filter
`default_nettype none

module tmwf_checker
(
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                sample_valid,
    input wire logic                                sample_stall,
    input wire logic                                average_valid,
    input wire logic                                average_stall,
    input wire logic signed [tmwf_pkg::SAMPLE_W-1:0] average
);
    import tmwf_pkg::*;

    // no result is offered out of reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !average_valid)
        else $error("average_valid high after a reset cycle");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        average_valid && average_stall |=> average_valid && $stable(average))
        else $error("stalled result changed");

    // the input side only closes after a transaction
    a_stall_after_txn: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_stall) |-> $past(sample_valid && !sample_stall))
        else $error("sample_stall rose without an input transaction");

    // a new result only appears while a sample is being worked on
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(average_valid) |-> $past(sample_stall))
        else $error("result appeared with no sample in progress");

endmodule

bind trimmed_mean_window_filter tmwf_checker u_tmwf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .average_valid (average_valid),
    .average_stall (average_stall),
    .average       (average)
);

`default_nettype wire

@@ verif/trimmed_mean_window_filter_test.sv @@
`timescale 1ns / 100ps
// trimmed_mean_window_filter_test: self-checking testbench of the trimmed mean window filter
// depends on tmwf_pkg and trimmed_mean_window_filter; predicts every average in its own model

module trimmed_mean_window_filter_test;

    import tmwf_pkg::*;

    // window size of the block under test
    localparam int WINDOW = 8;
    // cycles from an input transaction to its average: chain pass, trim, start,
    // one multiply step per 16-bit digit of the sum magnitude, output load
    localparam int LATENCY = WINDOW + 3 + (SAMPLE_W + $clog2(WINDOW) + 14) / 16;
    // cycles with no transaction on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // length of the long receiver hold-off
    localparam int LONG_HOLD = 200;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       average_valid;
    logic                       average_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] average;

    // predictor state: own copy of the ring window
    logic signed [SAMPLE_W-1:0] window_mem [WINDOW];
    int                         next_slot;
    int                         samples_seen;

    // averages still owed by the block, oldest first
    logic signed [SAMPLE_W-1:0] expected_means [$];

    // idling controls
    bit                         tx_idle_en = 1'b0;
    bit                         rx_idle_en = 1'b0;
    bit                         long_hold_req = 1'b0;

    int                         fail_count = 0;
    int                         samples_sent = 0;
    int                         averages_checked = 0;
    int                         quiet_cycles = 0;
    logic signed [SAMPLE_W-1:0] last_sample = '0;

    trimmed_mean_window_filter #(
        .WINDOW (WINDOW)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample        (sample),
        .average_valid (average_valid),
        .average_stall (average_stall),
        .average       (average)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ring window update plus trimmed mean; returns 1 once the window is full
    function automatic bit window_push_mean(input logic signed [SAMPLE_W-1:0] s,
                                            output logic signed [SAMPLE_W-1:0] mean);
        longint lo;
        longint hi;
        longint total;
        window_mem[next_slot] = s;
        next_slot = (next_slot + 1) % WINDOW;
        if (samples_seen < WINDOW)
            samples_seen++;
        mean = '0;
        if (samples_seen < WINDOW)
            return 1'b0;
        lo = window_mem[0];
        hi = window_mem[0];
        total = 0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (window_mem[i] < lo)
                lo = window_mem[i];
            if (window_mem[i] > hi)
                hi = window_mem[i];
            total += window_mem[i];
        end
        // exactly one min and one max leave, even when they repeat
        total = total - lo - hi;
        // signed division truncates toward zero
        mean = SAMPLE_W'(total / longint'(WINDOW - 2));
        return 1'b1;
    endfunction

    // one input transaction; entered at a falling edge, returns at a falling edge
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        logic signed [SAMPLE_W-1:0] mean;
        // optional gap before the transaction
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        // hold the payload until the block takes it
        do
            @(posedge clk);
        while (sample_stall);
        if (window_push_mean(s, mean))
            expected_means.push_back(mean);
        samples_sent++;
        last_sample = s;
        @(negedge clk);
    endtask

    // drop valid after a stretch of transactions
    task automatic release_input();
        sample_valid <= 1'b0;
        @(negedge clk);
    endtask

    // random sample: mostly full range, some small values, extremes and repeats
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom;
            6, 7:             return int'($urandom_range(0, 40)) - 20;
            8:                return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default:          return last_sample;
        endcase
    endfunction

    // receiver: random stall bursts, plus the long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                stall_left    = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            average_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // result checker: every accepted average against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && average_valid && !average_stall)
        begin
            if (expected_means.size() == 0)
            begin
                $error("average: unexpected transaction, actual %0d", average);
                fail_count++;
            end
            else
            begin
                if (average !== expected_means[0])
                begin
                    $error("average mismatch: expected %0d, actual %0d",
                           expected_means[0], average);
                    fail_count++;
                end
                void'(expected_means.pop_front());
                averages_checked++;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (average_valid && !average_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // filling with a mix that holds the field extremes, then windows of identical extremes
    task automatic test_fill_and_extremes();
        logic signed [SAMPLE_W-1:0] mixed [WINDOW];
        mixed = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, -32'sd1,
                  32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678};
        // the first seven only fill, the eighth gives the first average
        foreach (mixed[i])
            send_sample(mixed[i]);
        // all equal at the top and bottom of the range
        repeat (WINDOW) send_sample(32'sh7FFF_FFFF);
        repeat (WINDOW) send_sample(32'sh8000_0000);
        release_input();
    endtask

    // long random stream with idling on both sides
    task automatic test_random_stream(input int count);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (count) send_sample(pick_sample());
        release_input();
    endtask

    // receiver holds off while the sender keeps offering transactions
    task automatic test_backpressure();
        tx_idle_en    = 1'b0;
        long_hold_req = 1'b1;
        repeat (10) send_sample(pick_sample());
        release_input();
    endtask

    // closing stretch with no idling anywhere
    task automatic test_no_idle(input int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count) send_sample(pick_sample());
        release_input();
    endtask

    initial
    begin
        foreach (window_mem[i])
            window_mem[i] = '0;
        next_slot    = 0;
        samples_seen = 0;

        // single reset at the start of the run
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_fill_and_extremes();
        test_random_stream(390);
        test_backpressure();
        test_no_idle(30);

        // drain owed averages, then let the pipeline settle
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("covered %0d samples and %0d trimmed averages, incl. fill, extremes,",
                 samples_sent, averages_checked);
        $display("equal windows, random idling and a long output hold-off");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
